/* hw/rtl/bsfs_pkg.sv */
// bsfs_pkg: shared types and constants for the byte stuffing frame segmenter
// no dependencies; used by the interfaces, the burst builder and the top level
package bsfs_pkg;

  localparam int unsigned MAX_FRAME   = 4095;
  localparam int unsigned MIN_FRAME   = 4;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 12;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE  = 8'd0,
    REG_END_BYTE    = 8'd1,
    REG_ESCAPE_BYTE = 8'd2,
    REG_FRAME_SIZE  = 8'd3
  } cfg_reg_t;

  localparam byte_t START_RESET  = 8'h02;
  localparam byte_t END_RESET    = 8'h03;
  localparam byte_t ESCAPE_RESET = 8'h1B;
  localparam pos_t  SIZE_RESET   = 12'd64;

  typedef struct packed {
    byte_t start_b;
    byte_t end_b;
    byte_t esc_b;
    pos_t  frame_size;
  } cfg_t;

  typedef struct packed {
    byte_t [MAX_RESULTS-1:0] bytes;
    cnt_t                    count;
  } burst_t;

endpackage

/* hw/rtl/bsfs_in_if.sv */
// bsfs_in_if: input channel, one raw payload byte per beat
// depends on bsfs_pkg
interface bsfs_in_if;
  logic             valid;
  logic             ready;
  bsfs_pkg::byte_t  data_byte;
  logic             data_last;

  modport source (output valid, output data_byte, output data_last, input ready);
  modport sink   (input valid, input data_byte, input data_last, output ready);
endinterface

/* hw/rtl/bsfs_out_if.sv */
// bsfs_out_if: output channel, one framed stream byte per beat
// depends on bsfs_pkg
interface bsfs_out_if;
  logic             valid;
  logic             ready;
  bsfs_pkg::byte_t  out_byte;
  logic             run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* hw/rtl/bsfs_burst.sv */
// bsfs_burst: builds the one to five output bytes for one payload byte
// and the next frame position; depends on bsfs_pkg
module bsfs_burst (
  input  bsfs_pkg::cfg_t   cfg,
  input  bsfs_pkg::pos_t   pos,
  input  bsfs_pkg::byte_t  data_byte,
  input  logic             data_last,
  output bsfs_pkg::burst_t burst,
  output bsfs_pkg::pos_t   pos_next
);

  always_comb begin
    logic [bsfs_pkg::POS_W:0] m;
    logic [bsfs_pkg::POS_W:0] p;
    logic                     esc;
    bsfs_pkg::cnt_t           n;
    bsfs_pkg::byte_t [bsfs_pkg::MAX_RESULTS-1:0] b;

    // effective frame size, clamped to the legal range
    if (cfg.frame_size < bsfs_pkg::pos_t'(bsfs_pkg::MIN_FRAME)) begin
      m = (bsfs_pkg::POS_W+1)'(bsfs_pkg::MIN_FRAME);
    end else if ({1'b0, cfg.frame_size} > (bsfs_pkg::POS_W+1)'(bsfs_pkg::MAX_FRAME)) begin
      m = (bsfs_pkg::POS_W+1)'(bsfs_pkg::MAX_FRAME);
    end else begin
      m = {1'b0, cfg.frame_size};
    end

    p   = {1'b0, pos};
    n   = '0;
    b   = '0;
    esc = (data_byte == cfg.start_b) || (data_byte == cfg.end_b) ||
          (data_byte == cfg.esc_b);

    // frame already at or past its end slot
    if (p != '0 && p >= m - 1'b1) begin
      b[n] = cfg.end_b;
      n    = n + 1'b1;
      p    = '0;
    end
    if (p == '0) begin
      b[n] = cfg.start_b;
      n    = n + 1'b1;
      p    = (bsfs_pkg::POS_W+1)'(1);
    end
    if (esc) begin
      // pair would straddle frames: close early and reopen
      if (p == m - 2'd2) begin
        b[n] = cfg.end_b;
        n    = n + 1'b1;
        b[n] = cfg.start_b;
        n    = n + 1'b1;
        p    = (bsfs_pkg::POS_W+1)'(1);
      end
      b[n] = cfg.esc_b;
      n    = n + 1'b1;
      b[n] = data_byte;
      n    = n + 1'b1;
      p    = p + 2'd2;
    end else begin
      b[n] = data_byte;
      n    = n + 1'b1;
      p    = p + 1'b1;
    end
    if (p >= m - 1'b1) begin
      b[n] = cfg.end_b;
      n    = n + 1'b1;
      p    = '0;
    end
    if (data_last && p != '0) begin
      b[n] = cfg.end_b;
      n    = n + 1'b1;
      p    = '0;
    end

    burst.bytes = b;
    burst.count = n;
    pos_next    = p[bsfs_pkg::POS_W-1:0];
  end

endmodule

/* hw/rtl/byte_stuffing_frame_segmenter.sv */
// byte_stuffing_frame_segmenter: top level, config registers, frame position
// and the output burst register; depends on bsfs_pkg, bsfs_in_if, bsfs_out_if, bsfs_burst
//
//  channel    dir  payload                 handshake
//  data_in    in   data_byte[8] data_last  valid/ready
//  data_out   out  out_byte[8]  run_last   valid/ready
//  cfg        in   cfg_index[8] cfg_data   cfg_we, no back-pressure
//
// each payload byte yields 1 to 5 output beats, one per cycle while data_out is ready;
// a payload byte holds the input until its whole burst has left through the single output port
// the next payload beat is taken in the same cycle as the last beat of the
// current burst, so there is no bubble between bursts
// reset (rst, synchronous) empties the burst register, clears the frame position and
// restores the register defaults; stalls on data_out hold the burst in place
module byte_stuffing_frame_segmenter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bsfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  bsfs_in_if.sink                             data_in,
  bsfs_out_if.source                          data_out
);

  bsfs_pkg::cfg_t   cfg;
  bsfs_pkg::pos_t   pos;
  bsfs_pkg::pos_t   pos_next;
  bsfs_pkg::burst_t burst_new;
  bsfs_pkg::byte_t [bsfs_pkg::MAX_RESULTS-1:0] bytes;
  bsfs_pkg::cnt_t   count;
  logic             in_fire;
  logic             out_fire;

  bsfs_burst u_burst (
    .cfg       (cfg),
    .pos       (pos),
    .data_byte (data_in.data_byte),
    .data_last (data_in.data_last),
    .burst     (burst_new),
    .pos_next  (pos_next)
  );

  assign data_out.valid    = (count != '0);
  assign data_out.out_byte = bytes[0];
  assign data_out.run_last = (count == bsfs_pkg::cnt_t'(1));
  assign data_in.ready     = (count == '0) ||
                             (count == bsfs_pkg::cnt_t'(1) && data_out.ready);
  assign in_fire           = data_in.valid && data_in.ready;
  assign out_fire          = data_out.valid && data_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_b    <= bsfs_pkg::START_RESET;
      cfg.end_b      <= bsfs_pkg::END_RESET;
      cfg.esc_b      <= bsfs_pkg::ESCAPE_RESET;
      cfg.frame_size <= bsfs_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsfs_pkg::REG_START_BYTE:  cfg.start_b    <= cfg_data[bsfs_pkg::BYTE_W-1:0];
        bsfs_pkg::REG_END_BYTE:    cfg.end_b      <= cfg_data[bsfs_pkg::BYTE_W-1:0];
        bsfs_pkg::REG_ESCAPE_BYTE: cfg.esc_b      <= cfg_data[bsfs_pkg::BYTE_W-1:0];
        bsfs_pkg::REG_FRAME_SIZE:  cfg.frame_size <= cfg_data[bsfs_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos   <= '0;
    end else if (in_fire) begin
      count <= burst_new.count;
      pos   <= pos_next;
    end else if (out_fire) begin
      count <= count - 1'b1;
    end
  end

  // burst payload: load on accept, shift down one byte per beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes <= burst_new.bytes;
    end else if (out_fire) begin
      bytes <= {bsfs_pkg::BYTE_W'(0), bytes[bsfs_pkg::MAX_RESULTS-1:1]};
    end
  end

endmodule

/* dv/bsfs_stream_checker.sv */
`timescale 1ns / 100ps
// bsfs_stream_checker: watches the payload and stream channels and the register
// port, predicts the framed byte stream and compares every output beat
// depends on bsfs_pkg, bsfs_in_if and bsfs_out_if
module bsfs_stream_checker
  import bsfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bsfs_in_if                    in_ch,
  bsfs_out_if                   out_ch,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  typedef struct packed {
    byte_t value;
    logic  last;
  } framed_beat_t;

  framed_beat_t framed_q[$];
  byte_t        start_b;
  byte_t        end_b;
  byte_t        esc_b;
  pos_t         size_cfg;
  pos_t         frame_pos;

  initial mismatches = 0;

  task automatic frame_payload(input byte_t b, input logic last);
    int unsigned lim;
    int unsigned p;
    logic        marker;
    byte_t       run[$];
    lim = size_cfg;
    if (lim < MIN_FRAME) lim = MIN_FRAME;
    if (lim > MAX_FRAME) lim = MAX_FRAME;
    p = frame_pos;
    marker = (b == start_b) || (b == end_b) || (b == esc_b);
    // frame size lowered under an open frame
    if (p != 0 && p >= lim - 1) begin
      run.push_back(end_b);
      p = 0;
    end
    if (p == 0) begin
      run.push_back(start_b);
      p = 1;
    end
    if (marker) begin
      // escaped pair must not straddle two frames
      if (p == lim - 2) begin
        run.push_back(end_b);
        run.push_back(start_b);
        p = 1;
      end
      run.push_back(esc_b);
      run.push_back(b);
      p += 2;
    end else begin
      run.push_back(b);
      p += 1;
    end
    if (p >= lim - 1) begin
      run.push_back(end_b);
      p = 0;
    end
    if (last && p != 0) begin
      run.push_back(end_b);
      p = 0;
    end
    frame_pos = pos_t'(p);
    foreach (run[i]) framed_q.push_back('{value: run[i], last: (i == run.size() - 1)});
  endtask

  always @(posedge clk) begin
    framed_beat_t want;
    if (rst) begin
      start_b   = START_RESET;
      end_b     = END_RESET;
      esc_b     = ESCAPE_RESET;
      size_cfg  = SIZE_RESET;
      frame_pos = '0;
      framed_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (framed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual out_byte %h run_last %b",
                   $time, out_ch.out_byte, out_ch.run_last);
        end else begin
          want = framed_q.pop_front();
          if (out_ch.out_byte !== want.value || out_ch.run_last !== want.last) begin
            mismatches++;
            $display({"%0t: beat mismatch, expected out_byte %h run_last %b, ",
                      "actual out_byte %h run_last %b"},
                     $time, want.value, want.last, out_ch.out_byte, out_ch.run_last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_BYTE:  start_b = cfg_data[BYTE_W-1:0];
          REG_END_BYTE:    end_b = cfg_data[BYTE_W-1:0];
          REG_ESCAPE_BYTE: esc_b = cfg_data[BYTE_W-1:0];
          REG_FRAME_SIZE:  size_cfg = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) frame_payload(in_ch.data_byte, in_ch.data_last);
    end
    outstanding = framed_q.size();
  end

endmodule

/* dv/byte_stuffing_frame_segmenter_test.sv */
`timescale 1ns / 100ps
// byte_stuffing_frame_segmenter_test: drives payload beats and register writes,
// randomizes idling and back-pressure, and gives the verdict from bsfs_stream_checker
// depends on bsfs_pkg, bsfs_in_if, bsfs_out_if, the rtl top level and the checker
module byte_stuffing_frame_segmenter_test;
  import bsfs_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned BLOCKS        = 9;
  localparam int unsigned BLOCK_ITEMS   = 28;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           hold_requests = 0;
  int unsigned           mismatches;
  int unsigned           outstanding;
  byte_t                 cur_start = START_RESET;
  byte_t                 cur_end = END_RESET;
  byte_t                 cur_esc = ESCAPE_RESET;

  bsfs_in_if  in_ch();
  bsfs_out_if out_ch();

  byte_stuffing_frame_segmenter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_in   (in_ch),
    .data_out  (out_ch)
  );

  bsfs_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("byte_stuffing_frame_segmenter_test NOT OK");
    $finish;
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned seen_requests;
    hold_left = 0;
    seen_requests = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen_requests) begin
        seen_requests = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (cfg_reg_t'(idx))
      REG_START_BYTE:  cur_start = val[BYTE_W-1:0];
      REG_END_BYTE:    cur_end = val[BYTE_W-1:0];
      REG_ESCAPE_BYTE: cur_esc = val[BYTE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_payload(input byte_t b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = b;
    in_ch.data_last = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle_stream();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    byte_t b;
    logic  lst;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.data_last = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset markers, byte extremes and each marker value
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(START_RESET, 1'b0);
    send_payload(END_RESET, 1'b0);
    send_payload(ESCAPE_RESET, 1'b1);

    // smallest frame: full close, escape at the last slot, early close
    settle_stream();
    write_reg(REG_START_BYTE, 12'h07E);
    write_reg(REG_END_BYTE, 12'h07F);
    write_reg(REG_ESCAPE_BYTE, 12'h07D);
    write_reg(REG_FRAME_SIZE, 12'd4);
    send_payload(8'h11, 1'b0);
    send_payload(8'h22, 1'b0);
    send_payload(8'h7D, 1'b0);
    send_payload(8'h11, 1'b0);
    send_payload(8'h7E, 1'b0);
    send_payload(8'h55, 1'b1);

    // size below the minimum
    settle_stream();
    write_reg(REG_FRAME_SIZE, 12'd1);
    send_payload(8'h7F, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'h7D, 1'b1);

    // size lowered under an open frame
    settle_stream();
    write_reg(REG_FRAME_SIZE, 12'd64);
    for (int k = 0; k < 10; k++) send_payload(8'h30 + 8'(k), 1'b0);
    settle_stream();
    write_reg(REG_FRAME_SIZE, 12'd5);
    send_payload(8'h7F, 1'b1);

    // unused register index, then the largest frame
    settle_stream();
    write_reg(REG_FIRST_UNUSED, 12'hFFF);
    write_reg(REG_FRAME_SIZE, 12'd4095);
    send_payload(8'hA5, 1'b0);
    send_payload(8'h5A, 1'b1);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      settle_stream();
      case (blk / 3)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_START_BYTE, 12'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_END_BYTE, {4'($urandom), cur_start});
      else write_reg(REG_END_BYTE, 12'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_ESCAPE_BYTE, {4'($urandom), cur_end});
      else write_reg(REG_ESCAPE_BYTE, 12'($urandom));
      case (blk)
        0: write_reg(REG_FRAME_SIZE, 12'd0);
        4: write_reg(REG_FRAME_SIZE, 12'd4095);
        8: write_reg(REG_FRAME_SIZE, 12'd3);
        default: begin
          if ($urandom_range(4) == 0) write_reg(REG_FRAME_SIZE, 12'($urandom));
          else write_reg(REG_FRAME_SIZE, 12'($urandom_range(4, 24)));
        end
      endcase
      if (blk == 2) write_reg(CFG_IDX_W'($urandom_range(4, 255)), 12'($urandom));

      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if (blk == 1 && i == 4) hold_requests++;
        if (blk == 5 && i == 15) settle_stream();
        case ($urandom_range(9))
          0, 1: b = cur_start;
          2: b = cur_end;
          3: b = cur_esc;
          default: b = byte_t'($urandom);
        endcase
        lst = ($urandom_range(99) < 10);
        send_payload(b, lst);
      end
    end

    settle_stream();
    if (mismatches == 0) begin
      $display("byte_stuffing_frame_segmenter_test OK");
    end else begin
      $display("byte_stuffing_frame_segmenter_test NOT OK");
    end
    $finish;
  end

endmodule
